FILE: hw/rtl/tnm_pkg.sv
// tnm_pkg: shared widths, tile codes and register indexes for the tile
// neighbor mask block. No dependencies.
`default_nettype none

package tnm_pkg;

  // field and register widths
  localparam int unsigned CfgW   = 7;
  localparam int unsigned PosW   = 6;
  localparam int unsigned TileW  = 8;
  localparam int unsigned MaskW  = 4;
  localparam int unsigned CfgIdxW = 1;

  // default map limits
  localparam int unsigned MaxColsDef = 64;
  localparam int unsigned MaxRowsDef = 64;

  // tile type codes
  localparam logic [TileW-1:0] TileEmpty = 8'h30;
  localparam logic [TileW-1:0] TileSolid = 8'h31;

  // request codes
  localparam logic ReqWrite = 1'b0;
  localparam logic ReqQuery = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxMapCols = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxMapRows = 1'b1;

  // reset values of the map size registers
  localparam logic [CfgW-1:0] MapColsRst = 7'd64;
  localparam logic [CfgW-1:0] MapRowsRst = 7'd64;

  // neighbor mask bit positions
  localparam int unsigned DirUp    = 0;
  localparam int unsigned DirLeft  = 1;
  localparam int unsigned DirRight = 2;
  localparam int unsigned DirDown  = 3;

endpackage

`default_nettype wire

FILE: hw/rtl/tile_neighbor_mask.sv
// tile_neighbor_mask: top level with the map size registers, the sequencer
// and the tile memory. Depends on tnm_pkg, tnm_seq and tnm_tile_mem.
`default_nettype none

// Tile grid of MaxCols x MaxRows one-byte tile types at row * map_cols + col.
// After reset a clearing pass writes 0x30 to every entry, one per cycle;
// no item is taken during it, while the map size registers can be written
// at any time. A write item stores its byte if the position lies inside the
// map; no new item is taken until it is done. A query reads the centre and
// its four neighbors one after another through the single port of the tile
// memory, one access per cycle, then loads the result register once the
// output register is free, and only after that takes the next item. A query
// gives one result item, a write none. map_cols and map_rows are used
// saturated to 1..MaxCols and 1..MaxRows, each at most 127.
module tile_neighbor_mask #(
  parameter int unsigned MaxCols = tnm_pkg::MaxColsDef,
  parameter int unsigned MaxRows = tnm_pkg::MaxRowsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration
  input  wire logic                        cfg_we_i,
  input  wire logic [tnm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [tnm_pkg::CfgW-1:0]    cfg_data_i,
  // input items
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        req_type_i,
  input  wire logic [tnm_pkg::PosW-1:0]    col_i,
  input  wire logic [tnm_pkg::PosW-1:0]    row_i,
  input  wire logic [tnm_pkg::TileW-1:0]   tile_value_i,
  // result items
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [tnm_pkg::TileW-1:0]   tile_key_o,
  output logic      [tnm_pkg::MaskW-1:0]   neighbor_mask_o,
  output logic                             inside_map_o
);
  import tnm_pkg::*;

  localparam int unsigned Depth = MaxCols * MaxRows;
  localparam int unsigned AddrW = $clog2(Depth);

  logic [CfgW-1:0]  map_cols_q, map_rows_q;
  logic             mem_en, mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [TileW-1:0] mem_wdata, mem_rdata;

  // map size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_cols_q <= MapColsRst;
      map_rows_q <= MapRowsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIdxMapCols: map_cols_q <= cfg_data_i;
        CfgIdxMapRows: map_rows_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  tnm_seq #(
    .MaxCols (MaxCols),
    .MaxRows (MaxRows),
    .AddrW   (AddrW)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .map_cols_i      (map_cols_q),
    .map_rows_i      (map_rows_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .col_i           (col_i),
    .row_i           (row_i),
    .tile_value_i    (tile_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .tile_key_o      (tile_key_o),
    .neighbor_mask_o (neighbor_mask_o),
    .inside_map_o    (inside_map_o),
    .mem_en_o        (mem_en),
    .mem_we_o        (mem_we),
    .mem_addr_o      (mem_addr),
    .mem_wdata_o     (mem_wdata),
    .mem_rdata_i     (mem_rdata)
  );

  // tile memory
  tnm_tile_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/tnm_tile_mem.sv
// tnm_tile_mem: single-port tile type memory, one access per cycle,
// registered read data. Uses tnm_pkg for the tile width.
`default_nettype none

module tnm_tile_mem #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = 12
) (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic                      we_i,
  input  wire logic [AddrW-1:0]          addr_i,
  input  wire logic [tnm_pkg::TileW-1:0] wdata_i,
  output logic      [tnm_pkg::TileW-1:0] rdata_o
);
  import tnm_pkg::*;

  logic [TileW-1:0] mem_q [Depth];
  logic [TileW-1:0] rdata_q;

  // write or registered read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tnm_seq.sv
// tnm_seq: sequencer for the tile memory: clearing pass after reset,
// write items, five-read queries and the output register. Uses tnm_pkg.
`default_nettype none

module tnm_seq #(
  parameter int unsigned MaxCols = tnm_pkg::MaxColsDef,
  parameter int unsigned MaxRows = tnm_pkg::MaxRowsDef,
  parameter int unsigned AddrW   = 12
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // map size registers
  input  wire logic [tnm_pkg::CfgW-1:0]  map_cols_i,
  input  wire logic [tnm_pkg::CfgW-1:0]  map_rows_i,
  // input items
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      req_type_i,
  input  wire logic [tnm_pkg::PosW-1:0]  col_i,
  input  wire logic [tnm_pkg::PosW-1:0]  row_i,
  input  wire logic [tnm_pkg::TileW-1:0] tile_value_i,
  // result items
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic      [tnm_pkg::TileW-1:0] tile_key_o,
  output logic      [tnm_pkg::MaskW-1:0] neighbor_mask_o,
  output logic                           inside_map_o,
  // tile memory
  output logic                           mem_en_o,
  output logic                           mem_we_o,
  output logic      [AddrW-1:0]          mem_addr_o,
  output logic      [tnm_pkg::TileW-1:0] mem_wdata_o,
  input  wire logic [tnm_pkg::TileW-1:0] mem_rdata_i
);
  import tnm_pkg::*;

  localparam int unsigned Depth = MaxCols * MaxRows;
  localparam int unsigned IdxW  = PosW + CfgW + 1;
  localparam int unsigned ColSat = (MaxCols < 127) ? MaxCols : 127;
  localparam int unsigned RowSat = (MaxRows < 127) ? MaxRows : 127;
  localparam logic [CfgW-1:0] ColSatV = CfgW'(ColSat);
  localparam logic [CfgW-1:0] RowSatV = CfgW'(RowSat);
  localparam logic [CfgW-1:0] OneV    = CfgW'(1);
  localparam logic [AddrW-1:0] ClrLast = AddrW'(Depth - 1);

  // sequencer states
  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StSetup = 3'd2;
  localparam logic [2:0] StWrite = 3'd3;
  localparam logic [2:0] StRead  = 3'd4;
  localparam logic [2:0] StDrain = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;

  // read steps of a query
  localparam logic [2:0] StepCentre = 3'd0;
  localparam logic [2:0] StepUp     = 3'd1;
  localparam logic [2:0] StepLeft   = 3'd2;
  localparam logic [2:0] StepRight  = 3'd3;
  localparam logic [2:0] StepDown   = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic             req_q;
  logic [PosW-1:0]  col_q, row_q;
  logic [TileW-1:0] val_q;
  logic [IdxW-1:0]  base_q;
  logic             inside_q;
  logic [MaskW-1:0] nin_q;
  logic [2:0]       step_q, step_d;
  logic             pv_q, pv_d;
  logic [2:0]       pk_q;
  logic [TileW-1:0] key_q;
  logic [MaskW-1:0] mask_q;
  logic             out_valid_q, out_valid_d;
  logic [TileW-1:0] out_key_q;
  logic [MaskW-1:0] out_mask_q;
  logic             out_inside_q;

  logic [CfgW-1:0]  eff_cols, eff_rows;
  logic [CfgW-1:0]  col_x, row_x;
  logic             col_in, row_in, inside_c;
  logic [MaskW-1:0] nin_c;
  logic [IdxW-1:0]  base_c;
  logic [IdxW-1:0]  rd_idx;
  logic             rd_ok;
  logic             in_acc, out_load;

  // map size saturated to 1..max
  always_comb begin
    if (map_cols_i == '0) begin
      eff_cols = OneV;
    end else if (map_cols_i > ColSatV) begin
      eff_cols = ColSatV;
    end else begin
      eff_cols = map_cols_i;
    end
    if (map_rows_i == '0) begin
      eff_rows = OneV;
    end else if (map_rows_i > RowSatV) begin
      eff_rows = RowSatV;
    end else begin
      eff_rows = map_rows_i;
    end
  end

  // bounds of the latched position and its four neighbors
  always_comb begin
    col_x    = CfgW'(col_q);
    row_x    = CfgW'(row_q);
    col_in   = col_x < eff_cols;
    row_in   = row_x < eff_rows;
    inside_c = col_in && row_in;
    nin_c[DirUp]    = (row_q != '0) && ((row_x - OneV) < eff_rows) && col_in;
    nin_c[DirLeft]  = (col_q != '0) && ((col_x - OneV) < eff_cols) && row_in;
    nin_c[DirRight] = ((col_x + OneV) < eff_cols) && row_in;
    nin_c[DirDown]  = ((row_x + OneV) < eff_rows) && col_in;
    base_c = IdxW'(row_q) * IdxW'(eff_cols) + IdxW'(col_q);
  end

  // address of the current read step
  always_comb begin
    case (step_q)
      StepCentre: begin
        rd_idx = base_q;
        rd_ok  = inside_q;
      end
      StepUp: begin
        rd_idx = base_q - IdxW'(eff_cols);
        rd_ok  = nin_q[DirUp];
      end
      StepLeft: begin
        rd_idx = base_q - IdxW'(1);
        rd_ok  = nin_q[DirLeft];
      end
      StepRight: begin
        rd_idx = base_q + IdxW'(1);
        rd_ok  = nin_q[DirRight];
      end
      StepDown: begin
        rd_idx = base_q + IdxW'(eff_cols);
        rd_ok  = nin_q[DirDown];
      end
      default: begin
        rd_idx = '0;
        rd_ok  = 1'b0;
      end
    endcase
  end

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == StDone) && (!out_valid_q || out_ready_i);

  // next state, memory port and step control
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    step_d      = step_q;
    pv_d        = 1'b0;
    mem_en_o    = 1'b0;
    mem_we_o    = 1'b0;
    mem_addr_o  = '0;
    mem_wdata_o = TileEmpty;
    case (state_q)
      StClear: begin
        mem_en_o   = 1'b1;
        mem_we_o   = 1'b1;
        mem_addr_o = clr_q;
        clr_d      = clr_q + AddrW'(1);
        if (clr_q == ClrLast) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_acc) begin
          state_d = StSetup;
        end
      end
      StSetup: begin
        step_d  = StepCentre;
        state_d = (req_q == ReqWrite) ? StWrite : StRead;
      end
      StWrite: begin
        mem_en_o    = inside_q;
        mem_we_o    = 1'b1;
        mem_addr_o  = AddrW'(base_q);
        mem_wdata_o = val_q;
        state_d     = StIdle;
      end
      StRead: begin
        mem_en_o   = 1'b1;
        mem_addr_o = rd_ok ? AddrW'(rd_idx) : '0;
        pv_d       = 1'b1;
        step_d     = step_q + 3'd1;
        if (step_q == StepDown) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StDone;
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && !out_ready_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      step_q      <= StepCentre;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      step_q      <= step_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // latched item and bounds
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= req_type_i;
      col_q <= col_i;
      row_q <= row_i;
      val_q <= tile_value_i;
    end
    if (state_q == StSetup) begin
      base_q   <= base_c;
      inside_q <= inside_c;
      nin_q    <= nin_c;
    end
    if (state_q == StRead) begin
      pk_q <= step_q;
    end
  end

  // collect read data in the cycle after each read
  always_ff @(posedge clk_i) begin
    if (state_q == StSetup) begin
      key_q  <= TileEmpty;
      mask_q <= '0;
    end else if (pv_q) begin
      case (pk_q)
        StepCentre: if (inside_q) key_q <= mem_rdata_i;
        StepUp:     if (nin_q[DirUp] && mem_rdata_i == TileSolid) mask_q[DirUp] <= 1'b1;
        StepLeft:   if (nin_q[DirLeft] && mem_rdata_i == TileSolid) mask_q[DirLeft] <= 1'b1;
        StepRight:  if (nin_q[DirRight] && mem_rdata_i == TileSolid) mask_q[DirRight] <= 1'b1;
        StepDown:   if (nin_q[DirDown] && mem_rdata_i == TileSolid) mask_q[DirDown] <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_key_q    <= key_q;
      out_mask_q   <= mask_q;
      out_inside_q <= inside_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign tile_key_o      = out_key_q;
  assign neighbor_mask_o = out_mask_q;
  assign inside_map_o    = out_inside_q;

endmodule

`default_nettype wire
